// ----- hdl/sha256_pkg.sv -----
// Shared types and constants for the SHA-256 message hasher.
`default_nettype none
package sha256_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_req_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_req_t;

    // Queue entry between the front end and the compression engine.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } cmd_t;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] v;
        unique case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;
endpackage
`default_nettype wire

// ----- hdl/sha256_message_hasher.sv -----
// Top level of the SHA-256 message hasher.
// One message byte enters per request; an end-of-message request, with or
// without a byte, triggers padding and returns the digest as eight 32-bit
// requests, most significant word first. Each full 64-byte block is
// compressed in a load step, 64 rounds and a chain update. The end of a
// message adds the padding sweep up to byte 63, one or two compressions
// and eight output requests. A four-entry queue parts the accepting front
// end from the engine so input is taken while it works.
`default_nettype none
module sha256_message_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  sha256_pkg::in_req_t   in_req,
    input  wire                   in_valid,
    output logic                  in_ready,
    output sha256_pkg::out_req_t  out_req,
    output logic                  out_valid,
    input  wire                   out_ready
);
    sha256_pkg::cmd_t cmd;
    logic cmd_valid, cmd_ready;

    sha256_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk, .rst_n, .in_req, .in_valid, .in_ready,
        .cmd, .cmd_valid, .cmd_ready);

    sha256_core u_core (
        .clk, .rst_n, .cmd, .cmd_valid, .cmd_ready,
        .out_req, .out_valid, .out_ready);
endmodule
`default_nettype wire

// ----- hdl/sha256_front.sv -----
// Front end: accepts requests, drops empty ones and queues the rest.
`default_nettype none
module sha256_front #(
    parameter int DEPTH = 4
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  sha256_pkg::in_req_t in_req,
    input  wire                 in_valid,
    output logic                in_ready,
    output sha256_pkg::cmd_t    cmd,
    output logic                cmd_valid,
    input  wire                 cmd_ready
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha256_pkg::cmd_t fifo_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic push, pop, useful;

    assign useful    = in_req.byte_present | in_req.end_of_message;
    assign in_ready  = (count_reg != (AW+1)'(DEPTH));
    assign push      = in_valid & in_ready & useful;
    assign pop       = cmd_valid & cmd_ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= '{data_byte: in_req.data_byte,
                                      byte_present: in_req.byte_present,
                                      end_of_message: in_req.end_of_message};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH)) else $error("queue count above depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == (AW+1)'(DEPTH) |-> !in_ready) else $error("ready while full");
endmodule
`default_nettype wire

// ----- hdl/sha256_core.sv -----
// Back end: block buffer, padding, 64-round compression and digest output.
`default_nettype none
module sha256_core (
    input  wire                   clk,
    input  wire                   rst_n,
    input  sha256_pkg::cmd_t      cmd,
    input  wire                   cmd_valid,
    output logic                  cmd_ready,
    output sha256_pkg::out_req_t  out_req,
    output logic                  out_valid,
    input  wire                   out_ready
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_INIT  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] buf_mem [16];    // block buffer, four bytes per word, big-endian
    logic [5:0]  fill_reg;
    logic [63:0] bitlen_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [5:0]  round_reg;
    logic        ending_reg;      // compression is part of message end
    logic        final_reg;       // this compression is the last one
    logic        mark_pend_reg;   // the 0x80 marker is still to be written
    logic [2:0]  oidx_reg;
    logic [31:0] ld_word_reg;     // buffer word read for the next round

    logic take;
    assign cmd_ready = (state_reg == S_IDLE);
    assign take      = cmd_valid & cmd_ready;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Schedule word for the current round.
    logic [31:0] wt, s0, s1, x15, x2;
    assign x15 = w_reg[1];
    assign x2  = w_reg[14];
    assign s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    assign s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    assign wt  = (round_reg < 6'd16) ? ld_word_reg : (w_reg[0] + s0 + w_reg[9] + s1);

    logic [31:0] big0, big1, ch, maj, t1, t2;
    assign big1 = rotr(e_reg, 6) ^ rotr(e_reg, 11) ^ rotr(e_reg, 25);
    assign ch   = (e_reg & f_reg) ^ (~e_reg & g_reg);
    assign t1   = h_reg + big1 + ch + sha256_pkg::ROUND_K[round_reg] + wt;
    assign big0 = rotr(a_reg, 2) ^ rotr(a_reg, 13) ^ rotr(a_reg, 22);
    assign maj  = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
    assign t2   = big0 + maj;

    // Buffer byte written this cycle.
    logic       bw_en;
    logic [5:0] bw_addr;
    logic [7:0] bw_data;
    logic [3:0] rd_idx;

    // The padding sweep starts at the marker position, so its first byte is
    // 0x80; the rest is zeros, with the bit length in bytes 56 to 63 of the
    // last block.
    always_comb begin
        bw_en   = 1'b0;
        bw_addr = fill_reg;
        bw_data = cmd.data_byte;
        if (take && cmd.byte_present)
            bw_en = 1'b1;
        else if (state_reg == S_PAD) begin
            bw_en = 1'b1;
            if (mark_pend_reg)
                bw_data = sha256_pkg::PAD_BYTE;
            else if (final_reg && fill_reg >= 6'd56)
                bw_data = bitlen_reg[8'(63 - 8*(fill_reg - 6'd56)) -: 8];
            else
                bw_data = 8'h00;
        end
    end

    // In round t the next buffer word (t+1) is fetched; INIT fetches word 0.
    assign rd_idx = (state_reg == S_INIT) ? 4'd0 : round_reg[3:0] + 4'd1;

    always_ff @(posedge clk) begin
        if (bw_en)
            buf_mem[bw_addr[5:2]][{~bw_addr[1:0], 3'b000} +: 8] <= bw_data;
        ld_word_reg <= buf_mem[rd_idx];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (take) begin
                if (cmd.byte_present && fill_reg == 6'd63)
                    state_next = S_INIT;
                else if (cmd.end_of_message)
                    state_next = S_PAD;
            end
            S_PAD:   if (fill_reg == 6'd63) state_next = S_INIT;
            S_INIT:  state_next = S_ROUND;
            S_ROUND: if (round_reg == 6'd63) state_next = S_ADD;
            S_ADD: begin
                if (final_reg) state_next = S_OUT;
                else if (ending_reg) state_next = S_PAD;
                else state_next = S_IDLE;
            end
            S_OUT:   if (out_valid && out_ready && oidx_reg == 3'd7) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            bitlen_reg <= '0;
            round_reg  <= '0;
            ending_reg <= 1'b0;
            final_reg  <= 1'b0;
            oidx_reg   <= '0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= sha256_pkg::init_hash(3'(i));
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE: if (take) begin
                    if (cmd.byte_present) begin
                        fill_reg   <= fill_reg + 6'd1;
                        bitlen_reg <= bitlen_reg + 64'd8;
                    end
                    ending_reg <= cmd.end_of_message;
                    final_reg  <= 1'b0;
                end
                S_PAD:   fill_reg <= fill_reg + 6'd1;
                S_INIT:  round_reg <= '0;
                S_ROUND: round_reg <= round_reg + 6'd1;
                S_ADD: begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                    chain_reg[5] <= chain_reg[5] + f_reg;
                    chain_reg[6] <= chain_reg[6] + g_reg;
                    chain_reg[7] <= chain_reg[7] + h_reg;
                    oidx_reg <= '0;
                end
                S_OUT: if (out_valid && out_ready) begin
                    oidx_reg <= oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        for (int i = 0; i < 8; i++)
                            chain_reg[i] <= sha256_pkg::init_hash(3'(i));
                        fill_reg   <= '0;
                        bitlen_reg <= '0;
                        ending_reg <= 1'b0;
                        final_reg  <= 1'b0;
                    end
                end
                default: ;
            endcase
            // Entering padding: the length fits in this block only if the
            // marker lands below byte 56.
            if (state_reg == S_IDLE && take && cmd.end_of_message && !(cmd.byte_present
                && fill_reg == 6'd63)) begin
                final_reg <= (cmd.byte_present ? {1'b0, fill_reg} + 7'd1
                                               : {1'b0, fill_reg}) < 7'd56;
            end
            if (state_reg == S_ADD && ending_reg && !final_reg) begin
                // Wrapped into a second padding block (or marker still pending).
                final_reg <= 1'b1;
            end
        end
    end

    // The marker waits from the end request until the first padding byte.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            mark_pend_reg <= 1'b0;
        else if (take && cmd.end_of_message)
            mark_pend_reg <= 1'b1;
        else if (state_reg == S_PAD)
            mark_pend_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        unique case (state_reg)
            S_INIT: begin
                a_reg <= chain_reg[0]; b_reg <= chain_reg[1];
                c_reg <= chain_reg[2]; d_reg <= chain_reg[3];
                e_reg <= chain_reg[4]; f_reg <= chain_reg[5];
                g_reg <= chain_reg[6]; h_reg <= chain_reg[7];
            end
            S_ROUND: begin
                h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg;
                e_reg <= d_reg + t1;
                d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg;
                a_reg <= t1 + t2;
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= wt;
            end
            default: ;
        endcase
    end

    assign out_valid = (state_reg == S_OUT);
    assign out_req   = '{digest_word: chain_reg[oidx_reg], word_index: oidx_reg,
                         last_word: (oidx_reg == 3'd7)};

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_round_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INIT |=> state_reg == S_ROUND && round_reg == 6'd0)
        else $error("round counter not cleared");
    a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && oidx_reg == 3'd7 |=> state_reg == S_IDLE)
        else $error("digest did not finish");
    a_mark_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mark_pend_reg) else $error("marker left pending");
endmodule
`default_nettype wire
